/* rtl/bst_pkg.sv */
// Shared constants for the Born scattering term pipeline.
package bst_pkg;

  localparam int unsigned CFG_W     = 31;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_X     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Z     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_SPEED = 2'd2;

  localparam logic [CFG_W-1:0] GRID_STEP_RST  = 31'd655360;
  localparam logic [CFG_W-1:0] WAVE_SPEED_RST = 31'd98304000;

  localparam int unsigned OMEGA_W = 25;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned TERM_W  = 32;

  // Square root: radicand width, one result bit per stage.
  localparam int unsigned SQ_RAD_W = 65;
  localparam int unsigned SQ_STEPS = 34;
  localparam int unsigned SQ_REM_W = 68;

endpackage

/* rtl/bst_if.sv */
// Input and output channel interfaces of the Born scattering term block.
interface bst_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [bst_pkg::OMEGA_W-1:0]       omega;
  logic signed [bst_pkg::POS_W-1:0]         rec_x;
  logic signed [bst_pkg::POS_W-1:0]         rec_z;
  logic signed [bst_pkg::POS_W-1:0]         src_x;
  logic signed [bst_pkg::POS_W-1:0]         src_z;
  logic signed [bst_pkg::POS_W-1:0]         point_x;
  logic signed [bst_pkg::POS_W-1:0]         point_z;

  modport source (output valid, omega, rec_x, rec_z, src_x, src_z, point_x, point_z,
                  input ready);
  modport sink (input valid, omega, rec_x, rec_z, src_x, src_z, point_x, point_z,
                output ready);
endinterface

interface bst_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [bst_pkg::TERM_W-1:0]   term_re;
  logic signed [bst_pkg::TERM_W-1:0]   term_im;
  logic                                too_near;

  modport source (output valid, term_re, term_im, too_near, input ready);
  modport sink (input valid, term_re, term_im, too_near, output ready);
endinterface

/* rtl/bst_sqrt.sv */
// Pipelined integer square root, one result bit resolved per stage.
module bst_sqrt (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [bst_pkg::SQ_RAD_W-1:0]      rad_i,
  output logic [bst_pkg::SQ_STEPS-1:0]      root_o
);

  logic [bst_pkg::SQ_REM_W-1:0] rem_q  [bst_pkg::SQ_STEPS];
  logic [bst_pkg::SQ_STEPS-1:0] root_q [bst_pkg::SQ_STEPS];

  for (genvar j = 0; j < bst_pkg::SQ_STEPS; j++) begin : g_step
    localparam int unsigned B = bst_pkg::SQ_STEPS - 1 - j;
    logic [bst_pkg::SQ_REM_W-1:0] rem_in;
    logic [bst_pkg::SQ_REM_W-1:0] trial;
    logic [bst_pkg::SQ_STEPS-1:0] root_in;

    if (j == 0) begin : g_first
      assign rem_in  = bst_pkg::SQ_REM_W'(rad_i);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end

    // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b); the remainder holds s - r^2.
    assign trial = (bst_pkg::SQ_REM_W'(root_in) << (B + 1))
                 + (bst_pkg::SQ_REM_W'(1) << (2 * B));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in >= trial) begin
          rem_q[j]  <= rem_in - trial;
          root_q[j] <= root_in | (bst_pkg::SQ_STEPS'(1) << B);
        end else begin
          rem_q[j]  <= rem_in;
          root_q[j] <= root_in;
        end
      end
    end
  end

  assign root_o = root_q[bst_pkg::SQ_STEPS-1];

endmodule

/* rtl/born_scatter_term.sv */
// Born scattering term generator. One item is taken per clock unless the pipeline is
// halted; the whole pipeline advances together and halts only while a finished result
// waits at the output. The depth is set by the two 34-stage square roots for the
// distances, the 74-stage restoring divider that forms the phase (its magnitude
// divider runs alongside in the last 62 of those stages), and the fifteen stages of
// the sine and cosine series. Grid step and wave speed registers may be written only
// while no item is in flight.
module born_scatter_term (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bst_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bst_pkg::CFG_W-1:0]          cfg_wdata_i,
  bst_in_if.sink                             req_i,
  bst_out_if.source                          res_o
);

  localparam int unsigned DIV_STEPS   = 74;
  localparam int unsigned MAG_STEPS   = 62;
  localparam int unsigned N_TERMS     = 5;
  localparam int unsigned ST_SQ_OUT   = 3 + bst_pkg::SQ_STEPS;
  localparam int unsigned ST_PRE      = ST_SQ_OUT + 3;
  localparam int unsigned ST_DIV_END  = ST_PRE + DIV_STEPS;
  localparam int unsigned ST_TRIG     = ST_DIV_END + 3;
  localparam int unsigned N_TRM       = 3 * N_TERMS;
  localparam int unsigned N_ST        = ST_TRIG + N_TRM + 3;

  localparam logic [24:0] K_INV16PI2 = 25'd27198198;
  localparam logic [29:0] K_INV2PI   = 30'd683565276;
  localparam logic [30:0] K_HALFPI   = 31'd1686629713;

  typedef struct packed {
    logic [40:0] p;
    logic [24:0] wabs;
    logic        neg;
  } sb_t;

  typedef struct packed {
    logic [67:0] rm;
    logic [61:0] nm_lo;
    logic        cap;
    logic [46:0] rp;
    logic [73:0] np_lo;
    logic [31:0] qp;
    logic [61:0] qm;
    logic [67:0] dd;
    logic        near;
    logic        neg;
  } div_t;

  typedef struct packed {
    logic [30:0]        x_s;
    logic [30:0]        x_c;
    logic [30:0]        q_s;
    logic [30:0]        q_c;
    logic [30:0]        ts;
    logic [30:0]        tc;
    logic signed [32:0] ss;
    logic signed [32:0] sc;
    logic [29:0]        a2;
    logic [1:0]         quad;
    logic               swap;
    logic [62:0]        mag;
    logic               near;
  } trm_t;

  // Configuration registers.
  logic [bst_pkg::CFG_W-1:0] grid_x_q, grid_z_q, speed_q;
  logic [61:0]               gxz_q;
  logic [30:0]               c_eff;
  logic [46:0]               cdiv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_x_q <= bst_pkg::GRID_STEP_RST;
      grid_z_q <= bst_pkg::GRID_STEP_RST;
      speed_q  <= bst_pkg::WAVE_SPEED_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bst_pkg::REG_GRID_X:     grid_x_q <= cfg_wdata_i;
        bst_pkg::REG_GRID_Z:     grid_z_q <= cfg_wdata_i;
        bst_pkg::REG_WAVE_SPEED: speed_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    gxz_q <= 62'(grid_x_q) * 62'(grid_z_q);
  end

  // A wave speed of zero is taken as one LSB.
  assign c_eff = (speed_q == '0) ? 31'd1 : speed_q;
  assign cdiv  = {c_eff, 16'd0};

  // Pipeline control: every stage moves when the output register is empty or its result is taken.
  logic          en;
  logic [N_ST:1] vld_q;

  assign en          = !vld_q[N_ST] || res_o.ready;
  assign req_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[N_ST-1:1], req_i.valid};
    end
  end

  // Stage 1: coordinate differences and |omega|.
  logic signed [32:0] dsx, dsz, drx, drz;
  logic signed [24:0] om_neg;
  logic [31:0]        adsx_q, adsz_q, adrx_q, adrz_q;
  logic [24:0]        wabs1_q;
  logic               neg1_q;

  assign dsx    = 33'(req_i.point_x) - 33'(req_i.src_x);
  assign dsz    = 33'(req_i.point_z) - 33'(req_i.src_z);
  assign drx    = 33'(req_i.point_x) - 33'(req_i.rec_x);
  assign drz    = 33'(req_i.point_z) - 33'(req_i.rec_z);
  assign om_neg = -req_i.omega;

  always_ff @(posedge clk_i) begin
    if (en) begin
      adsx_q  <= dsx[32] ? 32'(-dsx) : 32'(dsx);
      adsz_q  <= dsz[32] ? 32'(-dsz) : 32'(dsz);
      adrx_q  <= drx[32] ? 32'(-drx) : 32'(drx);
      adrz_q  <= drz[32] ? 32'(-drz) : 32'(drz);
      wabs1_q <= req_i.omega[24] ? om_neg : req_i.omega;
      neg1_q  <= req_i.omega[24];
    end
  end

  // Stage 2: squares.
  logic [63:0] sqsx_q, sqsz_q, sqrx_q, sqrz_q;
  logic [48:0] wsq2_q;
  logic [24:0] wabs2_q;
  logic        neg2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqsx_q  <= 64'(adsx_q) * 64'(adsx_q);
      sqsz_q  <= 64'(adsz_q) * 64'(adsz_q);
      sqrx_q  <= 64'(adrx_q) * 64'(adrx_q);
      sqrz_q  <= 64'(adrz_q) * 64'(adrz_q);
      wsq2_q  <= 49'(50'(wabs1_q) * 50'(wabs1_q));
      wabs2_q <= wabs1_q;
      neg2_q  <= neg1_q;
    end
  end

  // Stage 3: radicands and the omega^2 / (16 pi^2) partial products.
  logic [bst_pkg::SQ_RAD_W-1:0] rad_src_q, rad_rec_q;
  logic [49:0]                  pl3_q;
  logic [48:0]                  ph3_q;
  logic [24:0]                  wabs3_q;
  logic                         neg3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_src_q <= 65'(sqsx_q) + 65'(sqsz_q);
      rad_rec_q <= 65'(sqrx_q) + 65'(sqrz_q);
      pl3_q     <= 50'(wsq2_q[24:0]) * 50'(K_INV16PI2);
      ph3_q     <= 49'(wsq2_q[48:25]) * 49'(K_INV16PI2);
      wabs3_q   <= wabs2_q;
      neg3_q    <= neg2_q;
    end
  end

  // Distances.
  logic [bst_pkg::SQ_STEPS-1:0] dist_src, dist_rec;

  bst_sqrt u_sqrt_src (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad_src_q),
    .root_o (dist_src)
  );

  bst_sqrt u_sqrt_rec (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad_rec_q),
    .root_o (dist_rec)
  );

  // Side band carried alongside the square roots.
  sb_t sb_q [bst_pkg::SQ_STEPS];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0].p    <= 41'((75'(pl3_q) + (75'(ph3_q) << 25)) >> 32);
      sb_q[0].wabs <= wabs3_q;
      sb_q[0].neg  <= neg3_q;
      for (int i = 1; i < bst_pkg::SQ_STEPS; i++) begin
        sb_q[i] <= sb_q[i-1];
      end
    end
  end

  // Stage after the roots: near test, distance product and partial products.
  sb_t         sb_end;
  logic        near_c;
  logic        near38_q, neg38_q;
  logic [67:0] dd38_q;
  logic [59:0] wds38_q;
  logic [51:0] pp0_q, pp1_q;
  logic [50:0] pp2_q, pp3_q;

  assign sb_end = sb_q[bst_pkg::SQ_STEPS-1];
  assign near_c = (dist_src == '0) || (dist_rec == '0)
               || (dist_src < 34'(grid_x_q)) || (dist_src < 34'(grid_z_q))
               || (dist_rec < 34'(grid_x_q)) || (dist_rec < 34'(grid_z_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      near38_q <= near_c;
      neg38_q  <= sb_end.neg;
      dd38_q   <= 68'(dist_src) * 68'(dist_rec);
      wds38_q  <= 60'(sb_end.wabs) * (60'(dist_src) + 60'(dist_rec));
      pp0_q    <= 52'(sb_end.p[20:0]) * 52'(gxz_q[30:0]);
      pp1_q    <= 52'(sb_end.p[20:0]) * 52'(gxz_q[61:31]);
      pp2_q    <= 51'(sb_end.p[40:21]) * 51'(gxz_q[30:0]);
      pp3_q    <= 51'(sb_end.p[40:21]) * 51'(gxz_q[61:31]);
    end
  end

  // Next stage: magnitude numerator and phase partial products.
  logic [86:0] nm39_q;
  logic [59:0] pnl39_q, pnh39_q;
  logic [67:0] dd39_q;
  logic        near39_q, neg39_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nm39_q   <= 87'((103'(pp0_q) + (103'(pp1_q) << 31) + (103'(pp2_q) << 21)
                      + (103'(pp3_q) << 52)) >> 16);
      pnl39_q  <= 60'(wds38_q[29:0]) * 60'(K_INV2PI);
      pnh39_q  <= 60'(wds38_q[59:30]) * 60'(K_INV2PI);
      dd39_q   <= dd38_q;
      near39_q <= near38_q;
      neg39_q  <= neg38_q;
    end
  end

  // Divider set-up. A quotient of 2^62 or more is capped, so only the low
  // 62 quotient bits of the magnitude are ever resolved.
  logic [89:0] np_c;
  div_t        dv_init_q;
  div_t        dv_q [DIV_STEPS];

  assign np_c = 90'(pnl39_q) + (90'(pnh39_q) << 30);

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_init_q.rm    <= 68'(nm39_q[86:62]);
      dv_init_q.nm_lo <= nm39_q[61:0];
      dv_init_q.cap   <= 68'(nm39_q[86:62]) >= dd39_q;
      dv_init_q.rp    <= 47'(np_c[89:74]);
      dv_init_q.np_lo <= np_c[73:0];
      dv_init_q.qp    <= '0;
      dv_init_q.qm    <= '0;
      dv_init_q.dd    <= dd39_q;
      dv_init_q.near  <= near39_q;
      dv_init_q.neg   <= neg39_q;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int unsigned B = DIV_STEPS - 1 - k;
    div_t        prev, nxt;
    logic [47:0] rp_sh;
    logic [68:0] rm_sh;

    if (k == 0) begin : g_first
      assign prev = dv_init_q;
    end else begin : g_next
      assign prev = dv_q[k-1];
    end

    assign rp_sh = {prev.rp, prev.np_lo[B]};

    if (B < MAG_STEPS) begin : g_mag
      assign rm_sh = {prev.rm, prev.nm_lo[B]};
    end else begin : g_nomag
      assign rm_sh = '0;
    end

    always_comb begin
      nxt = prev;
      if (rp_sh >= 48'(cdiv)) begin
        nxt.rp = 47'(rp_sh - 48'(cdiv));
        nxt.qp = {prev.qp[30:0], 1'b1};
      end else begin
        nxt.rp = 47'(rp_sh);
        nxt.qp = {prev.qp[30:0], 1'b0};
      end
      if (B < MAG_STEPS) begin
        if (rm_sh >= 69'(prev.dd)) begin
          nxt.rm = 68'(rm_sh - 69'(prev.dd));
          nxt.qm = {prev.qm[60:0], 1'b1};
        end else begin
          nxt.rm = 68'(rm_sh);
          nxt.qm = {prev.qm[60:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[k] <= nxt;
      end
    end
  end

  // Phase sign, quadrant and octant folding.
  div_t        dv_end;
  logic [31:0] phn;
  logic [29:0] fq;
  logic [29:0] f115_q;
  logic        swap115_q, near115_q;
  logic [1:0]  quad115_q;
  logic [62:0] mag115_q;

  assign dv_end = dv_q[DIV_STEPS-1];
  assign phn    = dv_end.neg ? (32'd0 - dv_end.qp) : dv_end.qp;
  assign fq     = phn[29:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      f115_q    <= fq[29] ? 30'(31'h4000_0000 - 31'(fq)) : fq;
      swap115_q <= fq[29];
      quad115_q <= phn[31:30];
      mag115_q  <= dv_end.cap ? (63'd1 << 62) : 63'(dv_end.qm);
      near115_q <= dv_end.near;
    end
  end

  // Octant angle in radians, Q30.
  logic [29:0] a116_q;
  logic        swap116_q, near116_q;
  logic [1:0]  quad116_q;
  logic [62:0] mag116_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a116_q    <= 30'((61'(f115_q) * 61'(K_HALFPI)) >> 30);
      swap116_q <= swap115_q;
      quad116_q <= quad115_q;
      mag116_q  <= mag115_q;
      near116_q <= near115_q;
    end
  end

  // Series set-up and the Taylor terms, three stages per term.
  trm_t trm_q [N_TRM + 1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      trm_q[0].x_s  <= '0;
      trm_q[0].x_c  <= '0;
      trm_q[0].q_s  <= '0;
      trm_q[0].q_c  <= '0;
      trm_q[0].ts   <= 31'(a116_q);
      trm_q[0].tc   <= 31'h4000_0000;
      trm_q[0].ss   <= 33'(a116_q);
      trm_q[0].sc   <= 33'sh4000_0000;
      trm_q[0].a2   <= 30'((60'(a116_q) * 60'(a116_q)) >> 30);
      trm_q[0].quad <= quad116_q;
      trm_q[0].swap <= swap116_q;
      trm_q[0].mag  <= mag116_q;
      trm_q[0].near <= near116_q;
    end
  end

  for (genvar n = 1; n <= N_TERMS; n++) begin : g_term
    localparam int unsigned J    = 3 * (n - 1);
    localparam int unsigned DS   = (2 * n) * (2 * n + 1);
    localparam int unsigned DC   = (2 * n - 1) * (2 * n);
    localparam logic [31:0] MS   = 32'((64'd1 << 32) / DS);
    localparam logic [31:0] MC   = 32'((64'd1 << 32) / DC);
    localparam logic        SUBT = (n % 2) == 1;
    trm_t        nxt_a, nxt_b, nxt_c;
    logic [37:0] rs, rc;
    logic [30:0] ts_n, tc_n;

    always_comb begin
      nxt_a     = trm_q[J];
      nxt_a.x_s = 31'((61'(trm_q[J].ts) * 61'(trm_q[J].a2)) >> 30);
      nxt_a.x_c = 31'((61'(trm_q[J].tc) * 61'(trm_q[J].a2)) >> 30);
    end

    always_comb begin
      nxt_b     = trm_q[J+1];
      nxt_b.q_s = 31'((63'(trm_q[J+1].x_s) * 63'(MS)) >> 32);
      nxt_b.q_c = 31'((63'(trm_q[J+1].x_c) * 63'(MC)) >> 32);
    end

    // The reciprocal estimate is at most one short of the true quotient.
    assign rs   = 38'(trm_q[J+2].x_s) - 38'(trm_q[J+2].q_s) * 38'(DS);
    assign rc   = 38'(trm_q[J+2].x_c) - 38'(trm_q[J+2].q_c) * 38'(DC);
    assign ts_n = (rs >= 38'(DS)) ? trm_q[J+2].q_s + 31'd1 : trm_q[J+2].q_s;
    assign tc_n = (rc >= 38'(DC)) ? trm_q[J+2].q_c + 31'd1 : trm_q[J+2].q_c;

    always_comb begin
      nxt_c    = trm_q[J+2];
      nxt_c.ts = ts_n;
      nxt_c.tc = tc_n;
      if (SUBT) begin
        nxt_c.ss = trm_q[J+2].ss - 33'(ts_n);
        nxt_c.sc = trm_q[J+2].sc - 33'(tc_n);
      end else begin
        nxt_c.ss = trm_q[J+2].ss + 33'(ts_n);
        nxt_c.sc = trm_q[J+2].sc + 33'(tc_n);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        trm_q[J+1] <= nxt_a;
        trm_q[J+2] <= nxt_b;
        trm_q[J+3] <= nxt_c;
      end
    end
  end

  // Quadrant mapping and magnitudes of cosine and sine.
  trm_t               trm_end;
  logic signed [32:0] s_oct, c_oct, co_c, si_c;
  logic [31:0]        ucos133_q, usin133_q;
  logic               ncos133_q, nsin133_q, near133_q;
  logic [62:0]        mag133_q;

  assign trm_end = trm_q[N_TRM];
  assign s_oct   = trm_end.swap ? trm_end.sc : trm_end.ss;
  assign c_oct   = trm_end.swap ? trm_end.ss : trm_end.sc;

  always_comb begin
    case (trm_end.quad)
      2'd0: begin
        co_c = c_oct;
        si_c = s_oct;
      end
      2'd1: begin
        co_c = -s_oct;
        si_c = c_oct;
      end
      2'd2: begin
        co_c = -c_oct;
        si_c = -s_oct;
      end
      default: begin
        co_c = s_oct;
        si_c = -c_oct;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ucos133_q <= co_c[32] ? 32'(-co_c) : 32'(co_c);
      usin133_q <= si_c[32] ? 32'(-si_c) : 32'(si_c);
      ncos133_q <= co_c[32];
      nsin133_q <= si_c[32];
      mag133_q  <= trm_end.mag;
      near133_q <= trm_end.near;
    end
  end

  // Magnitude times cosine and sine, split in two halves of the magnitude.
  logic [63:0] pcl_q, psl_q;
  logic [62:0] pch_q, psh_q;
  logic        ncos134_q, nsin134_q, near134_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pcl_q     <= 64'(mag133_q[31:0]) * 64'(ucos133_q);
      pch_q     <= 63'(mag133_q[62:32]) * 63'(ucos133_q);
      psl_q     <= 64'(mag133_q[31:0]) * 64'(usin133_q);
      psh_q     <= 63'(mag133_q[62:32]) * 63'(usin133_q);
      ncos134_q <= ncos133_q;
      nsin134_q <= nsin133_q;
      near134_q <= near133_q;
    end
  end

  function automatic logic [31:0] sat_term(input logic [64:0] v, input logic neg);
    logic [31:0] r;
    if (neg) begin
      if (v > 65'h0_8000_0000) begin
        r = 32'h8000_0000;
      end else begin
        r = 32'(65'd0 - v);
      end
    end else begin
      if (v > 65'h0_7FFF_FFFF) begin
        r = 32'h7FFF_FFFF;
      end else begin
        r = v[31:0];
      end
    end
    return r;
  endfunction

  // Output register.
  logic [64:0] vc, vs;
  logic [31:0] term_re_q, term_im_q;
  logic        near_q;

  assign vc = 65'((95'(pcl_q) + (95'(pch_q) << 32)) >> 30);
  assign vs = 65'((95'(psl_q) + (95'(psh_q) << 32)) >> 30);

  always_ff @(posedge clk_i) begin
    if (en) begin
      term_re_q <= near134_q ? 32'd0 : sat_term(vc, ncos134_q);
      term_im_q <= near134_q ? 32'd0 : sat_term(vs, nsin134_q);
      near_q    <= near134_q;
    end
  end

  assign res_o.valid    = vld_q[N_ST];
  assign res_o.term_re  = term_re_q;
  assign res_o.term_im  = term_im_q;
  assign res_o.too_near = near_q;

endmodule

/* tb/sv/born_scatter_term_tb.sv */
// Self-checking testbench for the Born scattering term block.
module born_scatter_term_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bst_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int unsigned DRAIN_CYCLES = 150;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam logic [CFG_W-1:0] CFG_MAX = 31'h7fff_ffff;

  typedef struct packed {
    logic signed [OMEGA_W-1:0] omega;
    logic signed [POS_W-1:0]   rec_x, rec_z, src_x, src_z, point_x, point_z;
  } scatter_item_t;

  typedef struct packed {
    logic [TERM_W-1:0] re;
    logic [TERM_W-1:0] im;
    logic              near;
  } term_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;

  bst_in_if  req ();
  bst_out_if res ();

  born_scatter_term DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req),
    .res_o       (res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [CFG_W-1:0] step_x, step_z, speed;
  term_t expected_terms[$];
  int    mismatches = 0;
  bit    gaps_on    = 1'b1;
  bit    hold_off   = 1'b0;

  // Distance: floor square root of the exact sum of squared differences.
  function automatic logic [33:0] distance(input logic signed [31:0] ax, az, bx, bz);
    logic signed [32:0] dx, dz;
    logic [32:0] ux, uz;
    logic [67:0] s;
    logic [33:0] r, c;
    dx = {ax[31], ax} - {bx[31], bx};
    dz = {az[31], az} - {bz[31], bz};
    ux = dx[32] ? -dx : dx;
    uz = dz[32] ? -dz : dz;
    s = 68'(ux) * 68'(ux) + 68'(uz) * 68'(uz);
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (34'd1 << b);
      if (68'(c) * 68'(c) <= s) r = c;
    end
    return r;
  endfunction

  function automatic void octant_series(input logic [63:0] f, output longint s,
                                        output longint c);
    logic [63:0] a, a2, ts, tc;
    a  = (f * 64'd1686629713) >> 30;
    a2 = (a * a) >> 30;
    ts = a;
    tc = 64'd1 << 30;
    s  = longint'(a);
    c  = longint'(tc);
    for (int k = 1; k <= 5; k++) begin
      ts = ((ts * a2) >> 30) / 64'((2 * k) * (2 * k + 1));
      tc = ((tc * a2) >> 30) / 64'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        s -= longint'(ts);
        c -= longint'(tc);
      end else begin
        s += longint'(ts);
        c += longint'(tc);
      end
    end
  endfunction

  function automatic logic [31:0] scale_part(input logic [62:0] mag, input longint t);
    logic [63:0] ut;
    logic [127:0] v;
    ut = t < 0 ? 64'(-t) : 64'(t);
    v  = (128'(mag) * 128'(ut)) >> 30;
    if (t < 0) begin
      if (v > (128'd1 << 31)) return 32'h8000_0000;
      return -v[31:0];
    end
    if (v > 128'h7fff_ffff) return 32'h7fff_ffff;
    return v[31:0];
  endfunction

  function automatic term_t predict_term(input scatter_item_t it);
    term_t t;
    logic [33:0] big_d, small_d;
    logic [24:0] wabs;
    logic [127:0] p, num, den, m, ph_full, cspd;
    logic [62:0] mag;
    logic [31:0] ph;
    longint co, si, sw;
    big_d   = distance(it.point_x, it.point_z, it.src_x, it.src_z);
    small_d = distance(it.point_x, it.point_z, it.rec_x, it.rec_z);
    if (big_d == 0 || small_d == 0 || big_d < step_x || big_d < step_z ||
        small_d < step_x || small_d < step_z) begin
      t.re = '0;
      t.im = '0;
      t.near = 1'b1;
      return t;
    end
    wabs = it.omega[24] ? 25'(-it.omega) : 25'(it.omega);
    p    = (128'(wabs) * 128'(wabs) * 128'd27198198) >> 32;
    num  = (p * (128'(step_x) * 128'(step_z))) >> 16;
    den  = 128'(big_d) * 128'(small_d);
    m    = num / den;
    mag  = (m > (128'd1 << 62)) ? (63'd1 << 62) : m[62:0];
    cspd = (speed == 0) ? 128'd1 : 128'(speed);
    ph_full = (128'(wabs) * (128'(big_d) + 128'(small_d)) * 128'd683565276) / (cspd << 16);
    ph = ph_full[31:0];
    if (it.omega[24]) ph = -ph;
    if (ph[29:0] < (30'd1 << 29)) octant_series(64'(ph[29:0]), si, co);
    else octant_series((64'd1 << 30) - 64'(ph[29:0]), co, si);
    case (ph[31:30])
      2'd1: begin
        sw = co; co = -si; si = sw;
      end
      2'd2: begin
        co = -co; si = -si;
      end
      2'd3: begin
        sw = co; co = si; si = -sw;
      end
      default: ;
    endcase
    t.re   = scale_part(mag, co);
    t.im   = scale_part(mag, si);
    t.near = 1'b0;
    return t;
  endfunction

  task automatic report(input string field, input logic [31:0] exp_v, act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h, got %h", field, exp_v, act_v);
  endtask

  // Result checker: every output transfer is compared with the oldest prediction.
  always @(posedge clk) begin
    term_t e;
    if (rst_n && res.valid && res.ready) begin
      if (expected_terms.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", res.term_re);
      end else begin
        e = expected_terms.pop_front();
        if (res.term_re !== e.re) report("term_re", e.re, res.term_re);
        if (res.term_im !== e.im) report("term_im", e.im, res.term_im);
        if (res.too_near !== e.near) report("too_near", 32'(e.near), 32'(res.too_near));
      end
    end
  end

  // Receiver: random stalls per result, and one long hold-off on request.
  initial begin
    int n;
    res.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off) begin
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
      n = gaps_on ? $urandom_range(0, 11) : 0;
      if (n > 0) begin
        res.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!res.valid);
    end
  end

  task automatic send_item(input scatter_item_t it);
    int gap;
    gap = gaps_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid   <= 1'b1;
    req.omega   <= it.omega;
    req.rec_x   <= it.rec_x;
    req.rec_z   <= it.rec_z;
    req.src_x   <= it.src_x;
    req.src_z   <= it.src_z;
    req.point_x <= it.point_x;
    req.point_z <= it.point_z;
    do @(posedge clk); while (!req.ready);
    expected_terms.push_back(predict_term(it));
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    wait (expected_terms.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GRID_X:     step_x = val;
      REG_GRID_Z:     step_z = val;
      REG_WAVE_SPEED: speed  = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [CFG_W-1:0] gx, gz, ws);
    drain();
    write_reg(REG_GRID_X, gx);
    write_reg(REG_GRID_Z, gz);
    write_reg(REG_WAVE_SPEED, ws);
  endtask

  function automatic scatter_item_t make_item(input int omega, rx, rz, sx, sz, px, pz);
    scatter_item_t it;
    it.omega = omega[24:0];
    it.rec_x = rx;   it.rec_z = rz;
    it.src_x = sx;   it.src_z = sz;
    it.point_x = px; it.point_z = pz;
    return it;
  endfunction

  // Mostly geometry around the scatter point, with some fully random items.
  function automatic scatter_item_t random_item();
    scatter_item_t it;
    int sh;
    it.omega   = 25'($urandom);
    it.rec_x   = $urandom;
    it.rec_z   = $urandom;
    it.src_x   = $urandom;
    it.src_z   = $urandom;
    it.point_x = $urandom;
    it.point_z = $urandom;
    if ($urandom_range(0, 3) != 0) begin
      sh = $urandom_range(4, 24);
      it.src_x = it.point_x + ($signed($urandom) >>> sh);
      it.src_z = it.point_z + ($signed($urandom) >>> sh);
      it.rec_x = it.point_x + ($signed($urandom) >>> sh);
      it.rec_z = it.point_z + ($signed($urandom) >>> sh);
    end
    return it;
  endfunction

  task automatic test_directed();
    int unsigned m = 32'h7fff_ffff;
    send_item(make_item(0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(65536, 0, 0, 1 << 22, 0, 0, 0));
    send_item(make_item(65536, 1 << 22, 0, 1 << 22, 0, 0, 0));
    send_item(make_item(0, 1 << 22, 1 << 21, -(1 << 22), 1 << 20, 0, 0));
    send_item(make_item(16777215, 1 << 22, 1 << 21, -(1 << 22), 1 << 20, 0, 0));
    send_item(make_item(-16777216, 1 << 22, 1 << 21, -(1 << 22), 1 << 20, 0, 0));
    send_item(make_item(-1, 1 << 22, 1 << 21, -(1 << 22), 1 << 20, 0, 0));
    send_item(make_item(1, 655360, 0, 0, 655360, 0, 0));
    send_item(make_item(1, 655359, 0, 0, 655360, 0, 0));
    send_item(make_item(300000, 0, 655359, 655360, 0, 0, 0));
    send_item(make_item(16777215, m, m, -m - 1, -m - 1, -m - 1, m));
    send_item(make_item(-16777216, -m - 1, -m - 1, m, m, m, -m - 1));
    send_item(make_item(16777215, 10 << 16, 0, 0, 10 << 16, 0, 0));
    send_item(make_item(-16777216, 11 << 16, 3 << 16, -(12 << 16), 5 << 16, 0, 0));
    send_item(make_item(5 << 16, 100 << 16, 7, 5, -(300 << 16), 1, 2));
    send_item(make_item(200 << 16, -(800 << 16), 40 << 16, 900 << 16, 60 << 16, 3, 3));
  endtask

  task automatic test_zero_registers();
    set_config(31'd0, 31'd0, 31'd0);
    send_item(make_item(65536, 0, 0, 0, 0, 0, 0));
    send_item(make_item(65536, 1, 0, 0, 1, 0, 0));
    send_item(make_item(-16777216, 1, 0, 0, 1, 0, 0));
    send_item(make_item(16777215, 1 << 20, 3, -5, 1 << 18, 0, 0));
    drain();
    write_reg(REG_SPARE, 31'h1234_5678);
    send_item(make_item(12345, 1 << 20, 3, -5, 1 << 18, 0, 0));
  endtask

  task automatic test_random(input logic [CFG_W-1:0] gx, gz, ws, input int count);
    set_config(gx, gz, ws);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) gaps_on = $urandom_range(0, 3) != 0;
      send_item(random_item());
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_backpressure();
    drain();
    gaps_on  = 1'b0;
    hold_off = 1'b1;
    for (int i = 0; i < 200; i++) send_item(random_item());
    gaps_on = 1'b1;
  endtask

  initial begin
    req.valid <= 1'b0;
    req.omega <= '0;
    req.rec_x <= '0;   req.rec_z <= '0;
    req.src_x <= '0;   req.src_z <= '0;
    req.point_x <= '0; req.point_z <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= REG_GRID_X;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    step_x = GRID_STEP_RST;
    step_z = GRID_STEP_RST;
    speed  = WAVE_SPEED_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_zero_registers();
    test_random(GRID_STEP_RST, GRID_STEP_RST, WAVE_SPEED_RST, 60);
    test_random(31'd1, 31'd1, 31'd65536, 50);
    test_random(31'd1, 31'd3 << 16, CFG_MAX, 40);
    test_random(CFG_MAX, 31'd1, 31'd20000 << 16, 30);
    test_random(31'd1 << 14, 31'd1 << 15, 31'd300 << 16, 50);
    test_backpressure();
    drain();
    mismatches += expected_terms.size();
    if (mismatches == 0) $display("born_scatter_term_tb: clean");
    else $display("born_scatter_term_tb: errors");
    $finish;
  end

  initial begin
    #3000000;
    $display("born_scatter_term_tb: errors");
    $finish;
  end

endmodule

/* files.f */
rtl/bst_pkg.sv
rtl/bst_if.sv
rtl/bst_sqrt.sv
rtl/born_scatter_term.sv
tb/sv/born_scatter_term_tb.sv
